>>> src/swmfc_pkg.sv
// ----------------------------------------------------------------------------
// swmfc_pkg
// Types and constants of the sliding-window maximum and fill cost unit.
// ----------------------------------------------------------------------------
package swmfc_pkg;

    localparam int SAMPLE_W = 32;
    localparam int WSIZE_W  = 11;
    localparam int SUM_W    = 43;
    localparam int PROD_W   = 44;
    localparam int OUT_W    = 42;
    localparam int TDATA_W  = 160;

    // register index on the configuration port
    localparam logic REG_WINDOW_SIZE = 1'b0;

    localparam logic [SUM_W-1:0] BEST_NONE = {SUM_W{1'b1}};

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EVICT = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_MAX   = 5'b01000,
        ST_COST  = 5'b10000
    } t_state;

endpackage

>>> src/sliding_window_max_fill_cost_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_max_fill_cost_unit
// Sliding-window maximum, sum and fill cost with a monotonic candidate queue.
// ----------------------------------------------------------------------------
// flow: an accepted sample steps through ST_EVICT, ST_SCAN (which repeats
// for each candidate dropped from the queue tail; the tail scan runs over the
// candidate memory read port), ST_MAX and ST_COST, which registers the result
// beat once the output is free; one sample at a time, taken only in ST_IDLE
// reset: synchronous active-low; control and sequence state clear at once,
// sample and candidate memories are not cleared and need no clearing pass
module sliding_window_max_fill_cost_unit
    import swmfc_pkg::*;
#(
    parameter int MAX_WINDOW = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [SAMPLE_W-1:0]  s_axis_tdata,   // [31:0] sample
    input  logic                 s_axis_tlast,   // last_sample
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [31:0] window_max, [73:32] window_sum, [115:74] fill_cost,
    // [157:116] best_cost, [159:158] zero
    output logic [TDATA_W-1:0]   m_axis_tdata,
    output logic                 m_axis_tuser,   // [0] window_valid
    output logic                 m_axis_tlast,   // sequence_done
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1) + 1;
    localparam int OW = AW + 18;

    typedef struct packed {
        logic [AW-1:0]              pos;
        logic signed [SAMPLE_W-1:0] val;
    } t_cand;

    // memories
    logic signed [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];
    t_cand                      cand_mem [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] r_ring_rd;
    t_cand                      r_cand_rd;

    // registers
    t_state                     r_state,      n_state;
    logic [WSIZE_W-1:0]         r_window_size, n_window_size;
    logic [WSIZE_W-1:0]         r_w,          n_w;
    logic signed [SAMPLE_W-1:0] r_sample,     n_sample;
    logic                       r_last,       n_last;
    logic [AW-1:0]              r_head,       n_head;
    logic [AW-1:0]              r_tail,       n_tail;
    logic [CW-1:0]              r_count,      n_count;
    logic [AW-1:0]              r_wp,         n_wp;
    logic [WSIZE_W-1:0]         r_fill,       n_fill;
    logic signed [SUM_W-1:0]    r_sum,        n_sum;
    logic [SUM_W-1:0]           r_best,       n_best;
    logic [AW-1:0]              r_oldest,     n_oldest;
    logic                       r_empty_push, n_empty_push;
    logic signed [SAMPLE_W-1:0] r_mx,         n_mx;
    logic signed [PROD_W-1:0]   r_prod,       n_prod;
    logic                       r_win_ok,     n_win_ok;
    logic                       r_out_valid,  n_out_valid;
    logic [TDATA_W-1:0]         r_out_data,   n_out_data;
    logic                       r_out_user,   n_out_user;
    logic                       r_out_last,   n_out_last;

    // combinational helpers
    logic [WSIZE_W-1:0]         w_eff;
    logic [OW-1:0]              w_old_t;
    logic [AW-1:0]              w_cand_raddr;
    logic                       w_cand_we;
    t_cand                      w_cand_wdata;
    logic                       w_ring_we;
    logic                       w_cfg_wr;
    logic                       w_evict;
    logic                       w_pop;
    logic signed [SAMPLE_W-1:0] w_mx;
    logic signed [PROD_W-1:0]   w_cost_full;
    logic [SUM_W-1:0]           w_cost;
    logic [SUM_W-1:0]           w_best;
    logic signed [SUM_W-1:0]    w_sum_sub;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(MAX_WINDOW - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        ptr_dec = (p == '0) ? AW'(MAX_WINDOW - 1) : p - AW'(1);
    endfunction

    // zero reads as one, oversize saturates
    always_comb begin
        if (r_window_size == '0) begin
            w_eff = WSIZE_W'(1);
        end else if (32'(r_window_size) > 32'(MAX_WINDOW)) begin
            w_eff = WSIZE_W'(MAX_WINDOW);
        end else begin
            w_eff = r_window_size;
        end
    end

    // ring position that drops out of the window
    always_comb begin
        w_old_t = OW'(r_wp) - OW'(w_eff);
        if (OW'(r_wp) < OW'(w_eff)) begin
            w_old_t = w_old_t + OW'(MAX_WINDOW);
        end
    end

    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE);
    assign w_evict  = (r_fill >= r_w);
    assign w_pop    = (r_count != '0) && !(r_cand_rd.val > r_sample);
    assign w_mx     = r_empty_push ? r_sample : r_cand_rd.val;

    assign w_cost_full = r_prod - PROD_W'(r_sum);
    assign w_cost      = w_cost_full[SUM_W-1:0];
    assign w_best      = (r_win_ok && (w_cost < r_best)) ? w_cost : r_best;
    assign w_sum_sub   = w_evict ? SUM_W'(r_ring_rd) : '0;

    assign w_ring_we    = (r_state == ST_EVICT);
    assign w_cand_we    = (r_state == ST_SCAN) && !w_pop;
    assign w_cand_wdata = '{pos: r_wp, val: r_sample};

    always_comb begin
        unique case (r_state)
            ST_IDLE:  w_cand_raddr = r_head;
            ST_EVICT: w_cand_raddr = ptr_dec(r_tail);
            ST_SCAN:  w_cand_raddr = w_pop ? ptr_dec(ptr_dec(r_tail)) : r_head;
            default:  w_cand_raddr = r_head;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            ring_mem[r_wp] <= r_sample;
        end
        r_ring_rd <= ring_mem[w_old_t[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_cand_we) begin
            cand_mem[r_tail] <= w_cand_wdata;
        end
        r_cand_rd <= cand_mem[w_cand_raddr];
    end

    always_comb begin
        n_state       = r_state;
        n_window_size = r_window_size;
        n_w           = r_w;
        n_sample      = r_sample;
        n_last        = r_last;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_wp          = r_wp;
        n_fill        = r_fill;
        n_sum         = r_sum;
        n_best        = r_best;
        n_oldest      = r_oldest;
        n_empty_push  = r_empty_push;
        n_mx          = r_mx;
        n_prod        = r_prod;
        n_win_ok      = r_win_ok;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_data    = r_out_data;
        n_out_user    = r_out_user;
        n_out_last    = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_sample = s_axis_tdata;
                    n_last   = s_axis_tlast;
                    n_w      = w_eff;
                    n_oldest = w_old_t[AW-1:0];
                    n_state  = ST_EVICT;
                end
            end
            ST_EVICT: begin
                if (w_evict) begin
                    n_fill = r_w - WSIZE_W'(1);
                    if ((r_count != '0) && (r_cand_rd.pos == r_oldest)) begin
                        n_head  = ptr_inc(r_head);
                        n_count = r_count - CW'(1);
                    end
                end
                n_sum   = r_sum - w_sum_sub + SUM_W'(r_sample);
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // drop tail candidates not above the new sample
                if (w_pop) begin
                    n_tail  = ptr_dec(r_tail);
                    n_count = r_count - CW'(1);
                end else begin
                    n_empty_push = (r_count == '0);
                    n_tail       = ptr_inc(r_tail);
                    n_count      = r_count + CW'(1);
                    n_wp         = ptr_inc(r_wp);
                    n_fill       = r_fill + WSIZE_W'(1);
                    n_state      = ST_MAX;
                end
            end
            ST_MAX: begin
                n_mx     = w_mx;
                n_prod   = PROD_W'($signed({1'b0, r_w})) * PROD_W'(w_mx);
                n_win_ok = (r_fill == r_w);
                n_state  = ST_COST;
            end
            ST_COST: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_win_ok;
                    n_out_last  = r_last;
                    n_out_data  = {2'b00, w_best[OUT_W-1:0],
                                   r_win_ok ? w_cost[OUT_W-1:0] : {OUT_W{1'b0}},
                                   r_win_ok ? r_sum[OUT_W-1:0] : {OUT_W{1'b0}},
                                   r_win_ok ? r_mx : {SAMPLE_W{1'b0}}};
                    n_best      = w_best;
                    if (r_last) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = '0;
                        n_wp    = '0;
                        n_fill  = '0;
                        n_sum   = '0;
                        n_best  = BEST_NONE;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a new size starts a new sequence
        if (w_cfg_wr) begin
            n_window_size = pwdata[WSIZE_W-1:0];
            n_head        = '0;
            n_tail        = '0;
            n_count       = '0;
            n_wp          = '0;
            n_fill        = '0;
            n_sum         = '0;
            n_best        = BEST_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_window_size <= WSIZE_W'(1);
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_wp          <= '0;
            r_fill        <= '0;
            r_sum         <= '0;
            r_best        <= BEST_NONE;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_window_size <= n_window_size;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_count       <= n_count;
            r_wp          <= n_wp;
            r_fill        <= n_fill;
            r_sum         <= n_sum;
            r_best        <= n_best;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w          <= n_w;
        r_sample     <= n_sample;
        r_last       <= n_last;
        r_oldest     <= n_oldest;
        r_empty_push <= n_empty_push;
        r_mx         <= n_mx;
        r_prod       <= n_prod;
        r_win_ok     <= n_win_ok;
        r_out_data   <= n_out_data;
        r_out_user   <= n_out_user;
        r_out_last   <= n_out_last;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? {21'b0, r_window_size} : 32'b0;

endmodule

>>> sim/tb_sliding_window_max_fill_cost_unit.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_max_fill_cost_unit
// Self-checking bench for the sliding-window maximum and fill cost unit. A
// short table of directed beats and register writes and one full-size window
// run are followed by random sequences of varied shape and window size. Every
// accepted sample is run through a behavioral window model, and each result
// beat is compared field by field with the oldest pending expectation, which a directed row may give itself.
// ----------------------------------------------------------------------------
module tb_sliding_window_max_fill_cost_unit;
    import swmfc_pkg::*;

    localparam int          HALF_PERIOD  = 6;
    localparam int          MAX_WIN      = 1024;
    localparam int          RANDOM_BEATS = 40;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam logic [2:0]  ADDR_WSIZE   = {REG_WINDOW_SIZE, 2'b00};
    localparam logic [2:0]  ADDR_SPARE   = 3'd4;  // no register behind it
    localparam logic [41:0] BEST_EMPTY   = BEST_NONE[OUT_W-1:0];

    typedef struct packed {
        logic        valid;
        logic [31:0] wmax;
        logic [41:0] wsum;
        logic [41:0] cost;
        logic [41:0] best;
        logic        done;
    } t_window_result;

    typedef enum logic { ROW_WRITE, ROW_BEAT } t_row_kind;

    typedef enum logic [2:0] {
        PAT_RANDOM, PAT_TIES, PAT_FALLING, PAT_RISING, PAT_EXTREME
    } t_pattern;

    typedef struct packed {
        t_row_kind      kind;
        logic [2:0]     addr;
        logic [31:0]    word;   // register value or sample
        logic           lst;
        logic           typed;  // res holds the expected result
        t_window_result res;
    } t_stim_row;

    localparam t_window_result NO_RESULT     = '0;
    localparam t_window_result NOT_FULL      = '{1'b0, 32'd0, 42'd0, 42'd0, BEST_EMPTY, 1'b0};
    localparam t_window_result NOT_FULL_LAST = '{1'b0, 32'd0, 42'd0, 42'd0, BEST_EMPTY, 1'b1};

    localparam t_stim_row DIRECTED [0:22] = '{
        // reset size of one: every sample is its own window
        '{ROW_BEAT,  ADDR_WSIZE, 32'd5,        1'b0, 1'b1,
          '{1'b1, 32'd5, 42'd5, 42'd0, 42'd0, 1'b0}},
        '{ROW_BEAT,  ADDR_WSIZE, 32'h7FFFFFFF, 1'b0, 1'b1,
          '{1'b1, 32'h7FFFFFFF, 42'h0007FFFFFFF, 42'd0, 42'd0, 1'b0}},
        '{ROW_BEAT,  ADDR_WSIZE, 32'h80000000, 1'b1, 1'b1,
          '{1'b1, 32'h80000000, 42'h3FF80000000, 42'd0, 42'd0, 1'b1}},
        // size zero behaves as one
        '{ROW_WRITE, ADDR_WSIZE, 32'd0,        1'b0, 1'b0, NO_RESULT},
        '{ROW_BEAT,  ADDR_WSIZE, 32'hFFFFFFFF, 1'b0, 1'b1,
          '{1'b1, 32'hFFFFFFFF, 42'h3FFFFFFFFFF, 42'd0, 42'd0, 1'b0}},
        '{ROW_WRITE, ADDR_WSIZE, 32'd3,        1'b0, 1'b0, NO_RESULT},
        '{ROW_BEAT,  ADDR_WSIZE, 32'd10,       1'b0, 1'b1, NOT_FULL},
        '{ROW_BEAT,  ADDR_WSIZE, 32'd10,       1'b0, 1'b0, NO_RESULT},
        '{ROW_BEAT,  ADDR_WSIZE, 32'd10,       1'b0, 1'b1,
          '{1'b1, 32'd10, 42'd30, 42'd0, 42'd0, 1'b0}},
        '{ROW_BEAT,  ADDR_WSIZE, 32'h80000000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BEAT,  ADDR_WSIZE, 32'h7FFFFFFF, 1'b1, 1'b0, NO_RESULT},
        // write to an unmapped index leaves size and state alone
        '{ROW_WRITE, ADDR_SPARE, 32'd7,        1'b0, 1'b0, NO_RESULT},
        '{ROW_BEAT,  ADDR_WSIZE, 32'd1,        1'b1, 1'b1, NOT_FULL_LAST},
        '{ROW_WRITE, ADDR_WSIZE, 32'd2,        1'b0, 1'b0, NO_RESULT},
        '{ROW_BEAT,  ADDR_WSIZE, 32'h7FFFFFFF, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BEAT,  ADDR_WSIZE, 32'h80000000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BEAT,  ADDR_WSIZE, 32'h80000000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BEAT,  ADDR_WSIZE, 32'd4,        1'b0, 1'b0, NO_RESULT},
        // rewriting the size drops the open sequence
        '{ROW_WRITE, ADDR_WSIZE, 32'd2,        1'b0, 1'b0, NO_RESULT},
        '{ROW_BEAT,  ADDR_WSIZE, 32'd9,        1'b0, 1'b1, NOT_FULL},
        '{ROW_BEAT,  ADDR_WSIZE, 32'd9,        1'b1, 1'b0, NO_RESULT},
        // oversize saturates to the largest window
        '{ROW_WRITE, ADDR_WSIZE, 32'd2047,     1'b0, 1'b0, NO_RESULT},
        '{ROW_BEAT,  ADDR_WSIZE, 32'd0,        1'b1, 1'b1, NOT_FULL_LAST}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata;   // [31:0] sample
    logic                s_axis_tlast;   // last_sample
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // [31:0] window_max, [73:32] window_sum, [115:74] fill_cost,
    // [157:116] best_cost, [159:158] zero
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic                m_axis_tuser;   // [0] window_valid
    logic                m_axis_tlast;   // sequence_done
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // window model
    logic [WSIZE_W-1:0]  wsize_reg;
    int                  window_q[$];
    longint              window_sum;
    logic [SUM_W-1:0]    best_run;

    t_window_result      pending_results[$];
    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    bit                  no_idle;
    int                  hold_req = 0;

    sliding_window_max_fill_cost_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int window_len();
        if (wsize_reg == 0) return 1;
        if (wsize_reg > MAX_WIN) return MAX_WIN;
        return int'(wsize_reg);
    endfunction

    function automatic void clear_window();
        window_q.delete();
        window_sum = 0;
        best_run   = BEST_NONE;
    endfunction

    // slide one sample into the window and work out the result beat
    function automatic t_window_result predict_window(logic [31:0] smp, logic lst);
        int             w;
        int             s;
        int             mx;
        longint         cost;
        logic [42:0]    c;
        t_window_result r;
        w = window_len();
        s = smp;
        r = '0;
        if (window_q.size() >= w)
            window_sum -= window_q.pop_front();
        window_q.insert(window_q.size(), s);
        window_sum += s;
        if (window_q.size() == w) begin
            mx = window_q[0];
            foreach (window_q[k])
                if (window_q[k] > mx) mx = window_q[k];
            cost = longint'(w) * longint'(mx) - window_sum;
            c    = cost[42:0];
            if (c < best_run) best_run = c;
            r.valid = 1'b1;
            r.wmax  = mx;
            r.wsum  = window_sum[41:0];
            r.cost  = c[41:0];
        end
        r.best = best_run[41:0];
        r.done = lst;
        if (lst) clear_window();
        return r;
    endfunction

    function automatic logic [31:0] next_sample(t_pattern pat, ref int run);
        int t;
        case (pat)
            PAT_TIES: begin
                t = $urandom_range(0, 8);
                return t - 4;
            end
            PAT_FALLING: begin
                run = run - $urandom_range(0, 2);
                return run;
            end
            PAT_RISING: begin
                run = run + $urandom_range(0, 2);
                return run;
            end
            PAT_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFFFFFF;
                    1: return 32'h80000000;
                    2: return 32'd0;
                    default: return $urandom;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic push_sample(input logic [31:0] smp, input logic lst,
                               input logic typed, input t_window_result typed_res);
        int             gap;
        t_window_result r;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_window(smp, lst);
        pending_results.insert(pending_results.size(), typed ? typed_res : r);
    endtask

    // stop offering samples and wait for every result to come back
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        drain_results();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_WSIZE) begin
            wsize_reg = value[WSIZE_W-1:0];
            clear_window();
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        int holds_done;
        holds_done    = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req > holds_done) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_done++;
            end
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_window_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no prediction pending");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("window_valid",  want.valid, m_axis_tuser);
                check_field("window_max",    want.wmax,  m_axis_tdata[31:0]);
                check_field("window_sum",    want.wsum,  m_axis_tdata[73:32]);
                check_field("fill_cost",     want.cost,  m_axis_tdata[115:74]);
                check_field("best_cost",     want.best,  m_axis_tdata[157:116]);
                check_field("sequence_done", want.done,  m_axis_tlast);
            end
        end
    end

    initial begin
        int          random_beats;
        int          phase;
        int          nseq;
        int          len;
        int          w_eff;
        int          run;
        logic [10:0] size;
        logic [31:0] smp;
        logic        lst;
        t_pattern    pat;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        no_idle       = 1'b0;
        wsize_reg     = 11'd1;
        clear_window();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_WRITE)
                write_reg(DIRECTED[i].addr, DIRECTED[i].word);
            else
                push_sample(DIRECTED[i].word, DIRECTED[i].lst,
                            DIRECTED[i].typed, DIRECTED[i].res);
        end

        // full-size window: long falling run builds a long candidate queue, then
        // the ring write pointer wraps and one large sample sweeps the whole queue
        run = 32'h40000000;
        for (int i = 0; i < 1030; i++) begin
            if (i == 1025)     smp = 32'h7FFFFFFF;
            else if (i < 1020) smp = next_sample(PAT_FALLING, run);
            else               smp = $urandom;
            push_sample(smp, i == 1029, 1'b0, NO_RESULT);
        end

        random_beats = 0;
        phase = 0;
        while (random_beats < RANDOM_BEATS) begin
            phase++;
            case ($urandom_range(0, 19))
                0:       size = 11'd0;
                1:       size = 11'd1;
                2:       size = $urandom_range(1024, 2047);
                3, 4:    size = $urandom_range(9, 64);
                default: size = $urandom_range(2, 8);
            endcase
            write_reg(ADDR_WSIZE, {21'($urandom), size});
            if ($urandom_range(0, 9) == 0)
                write_reg(ADDR_SPARE, $urandom);
            w_eff = window_len();
            no_idle = ($urandom_range(0, 3) == 0);
            nseq = $urandom_range(1, 4);
            if (phase % 5 == 1) begin
                hold_req++;
                nseq = 4;
            end
            for (int q = 0; q < nseq && random_beats < RANDOM_BEATS; q++) begin
                len = $urandom_range(1, (w_eff <= 64) ? 3 * w_eff + 8 : 24);
                if (len > RANDOM_BEATS - random_beats) len = RANDOM_BEATS - random_beats;
                pat = t_pattern'($urandom_range(0, 4));
                run = $urandom;
                for (int k = 0; k < len; k++) begin
                    smp = next_sample(pat, run);
                    // now and then the final sequence is left open
                    lst = (k == len - 1) && !(q == nseq - 1 && $urandom_range(0, 3) == 0);
                    push_sample(smp, lst, 1'b0, NO_RESULT);
                    random_beats++;
                end
            end
        end

        drain_results();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/swmfc_pkg.sv
src/sliding_window_max_fill_cost_unit.sv
sim/tb_sliding_window_max_fill_cost_unit.sv
